FILE: rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg: shared definitions for the seven-segment scan driver
// Widths, reset values, command and register codes, item and result types,
// and the segment font tables.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 3;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned TIMEOUT_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0]    DIGIT_ON_RST = 16'd1000;
  localparam logic [TICK_W-1:0]    BLANK_RST    = 16'd15000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 32'd5000000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_VALUE = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_LP_START  = 2'd2,
    CMD_LP_END    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIGIT_ON = 2'd0,
    CFG_BLANK    = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } step_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
  } result_t;

  // Quotient of a 16-bit value by 10**k, by reciprocal multiplication.
  function automatic logic [VALUE_W-1:0] div_pow10(input logic [VALUE_W-1:0] v,
                                                   input int unsigned k);
    logic [32:0] p;
    begin
      p = '0;
      case (k)
        0: return v;
        1: begin
          p = {17'd0, v} * 33'd104858;
          return VALUE_W'(p >> 20);
        end
        2: begin
          p = {17'd0, v} * 33'd83887;
          return VALUE_W'(p >> 23);
        end
        3: begin
          p = {17'd0, v} * 33'd67109;
          return VALUE_W'(p >> 26);
        end
        4: begin
          p = {17'd0, v} * 33'd107375;
          return VALUE_W'(p >> 30);
        end
        default: return '0;
      endcase
    end
  endfunction

  function automatic logic [SEG_W-1:0] seg_font(input logic [DIGIT_W-1:0] d);
    case (d)
      4'd0, 4'd10: return 7'h3F;
      4'd1, 4'd11: return 7'h06;
      4'd2, 4'd12: return 7'h5B;
      4'd3, 4'd13: return 7'h4F;
      4'd4, 4'd14: return 7'h66;
      4'd5, 4'd15: return 7'h6D;
      4'd6:        return 7'h7D;
      4'd7:        return 7'h07;
      4'd8:        return 7'h7F;
      4'd9:        return 7'h6F;
      default:     return 7'h00;
    endcase
  endfunction

  function automatic logic [SEG_W-1:0] lp_font(input logic [3:0] pos);
    case (pos)
      4'd0:    return 7'h73;
      4'd1:    return 7'h38;
      4'd2:    return 7'h5C;
      default: return 7'h00;
    endcase
  endfunction

endpackage

FILE: rtl/ssd_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_digit_split: binary to decimal digit splitter
// Splits a 16-bit value into its low decimal digits, most significant first.
// ----------------------------------------------------------------------------
module ssd_digit_split #(
  parameter int unsigned NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
  input  logic [ssd_pkg::VALUE_W-1:0]                   value_i,
  output logic [NUM_DIGITS-1:0][ssd_pkg::DIGIT_W-1:0]   digits_o
);

  logic [ssd_pkg::VALUE_W-1:0] quot [NUM_DIGITS+1];

  for (genvar k = 0; k <= NUM_DIGITS; k++) begin : g_quot
    assign quot[k] = ssd_pkg::div_pow10(value_i, k);
  end

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
    assign digits_o[NUM_DIGITS-1-k] =
      ssd_pkg::DIGIT_W'(quot[k] - ((quot[k+1] << 3) + (quot[k+1] << 1)));
  end

endmodule

FILE: rtl/ssd_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_scan_ctrl: scan state, timeout and segment decode
// Holds the configuration registers and display state, applies one item per
// cycle while fire is set and produces the segment and digit pattern for it.
// ----------------------------------------------------------------------------
module ssd_scan_ctrl #(
  parameter int unsigned NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  ssd_pkg::step_t                 step_i,
  output ssd_pkg::result_t               result_o
);

  localparam int unsigned PHASE_W = $clog2(NUM_DIGITS + 1);
  localparam int unsigned IDX_W   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [PHASE_W-1:0] BLANK_PHASE = PHASE_W'(NUM_DIGITS);

  logic [ssd_pkg::TICK_W-1:0]    digit_on_q;
  logic [ssd_pkg::TICK_W-1:0]    blank_q;
  logic [ssd_pkg::TIMEOUT_W-1:0] timeout_q;

  logic [NUM_DIGITS-1:0][ssd_pkg::DIGIT_W-1:0] digits_q, digits_d, split_digits;
  logic [PHASE_W-1:0]            phase_q, phase_d;
  logic [ssd_pkg::TICK_W-1:0]    count_q, count_d;
  logic [ssd_pkg::TIMEOUT_W-1:0] left_q, left_d;
  logic                          blanked_q, blanked_d;
  logic                          lp_q, lp_d;

  logic [ssd_pkg::TICK_W-1:0]  phase_len;
  logic [ssd_pkg::TICK_W-1:0]  count_inc;
  logic                        phase_end;
  logic [PHASE_W-1:0]          phase_next;
  logic                        shown;
  logic [ssd_pkg::DIGIT_W-1:0] cur_digit;

  ssd_digit_split #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_split (
    .value_i (step_i.item.value),
    .digits_o(split_digits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_on_q <= ssd_pkg::DIGIT_ON_RST;
      blank_q    <= ssd_pkg::BLANK_RST;
      timeout_q  <= ssd_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (ssd_pkg::cfg_idx_e'(cfg_idx_i))
        ssd_pkg::CFG_DIGIT_ON: digit_on_q <= cfg_wdata_i[ssd_pkg::TICK_W-1:0];
        ssd_pkg::CFG_BLANK:    blank_q    <= cfg_wdata_i[ssd_pkg::TICK_W-1:0];
        ssd_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i[ssd_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_len = (phase_q < BLANK_PHASE) ? digit_on_q : blank_q;
    count_inc = count_q + 16'd1;
    phase_end = (count_inc >= phase_len) || (count_inc == '0);
    phase_next = (phase_q == BLANK_PHASE) ? '0 : phase_q + 1'b1;
    if ((phase_next == BLANK_PHASE) && (blank_q == '0)) begin
      phase_next = '0;
    end
  end

  always_comb begin
    digits_d  = digits_q;
    phase_d   = phase_q;
    count_d   = count_q;
    left_d    = left_q;
    blanked_d = blanked_q;
    lp_d      = lp_q;
    if (step_i.fire) begin
      case (step_i.item.cmd)
        ssd_pkg::CMD_SET_VALUE: begin
          digits_d  = split_digits;
          left_d    = timeout_q;
          blanked_d = 1'b0;
        end
        ssd_pkg::CMD_TICK: begin
          if (left_q == '0) begin
            blanked_d = 1'b1;
          end else begin
            left_d = left_q - 1'b1;
          end
          if (phase_end) begin
            count_d = '0;
            phase_d = phase_next;
          end else begin
            count_d = count_inc;
          end
        end
        ssd_pkg::CMD_LP_START: lp_d = 1'b1;
        ssd_pkg::CMD_LP_END:   lp_d = 1'b0;
        default: ;
      endcase
    end
  end

  // The result shows the phase driven during this item, with the updated
  // digits, blanking and low-power mode.
  always_comb begin
    shown     = (phase_q < BLANK_PHASE) && (32'(phase_q) < 32'(ssd_pkg::SEL_W));
    cur_digit = digits_d[phase_q[IDX_W-1:0]];
    result_o.digit_select = '0;
    result_o.segments     = '0;
    if (shown) begin
      result_o.digit_select = ssd_pkg::SEL_W'(ssd_pkg::SEL_W'(1) << phase_q);
      if (lp_d) begin
        result_o.segments = ssd_pkg::lp_font(4'(phase_q));
      end else if (!blanked_d) begin
        result_o.segments = ssd_pkg::seg_font(cur_digit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q  <= '0;
      phase_q   <= '0;
      count_q   <= '0;
      left_q    <= '0;
      blanked_q <= 1'b1;
      lp_q      <= 1'b0;
    end else begin
      digits_q  <= digits_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      left_q    <= left_d;
      blanked_q <= blanked_d;
      lp_q      <= lp_d;
    end
  end

endmodule

FILE: rtl/seven_segment_scan_driver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit: multiplexed seven-segment display driver
// Items arrive on the input channel as a command and a value: set value,
// tick, low-power start or low-power end. Every item gives exactly one
// result on the output channel: the segment pattern and one-hot or zero digit
// select that the display shows for that item. Tick items step the scan,
// lighting each digit for digit_on_ticks ticks and then leaving all digits
// off for blank_ticks ticks; a set value restarts a timeout of
// timeout_ticks ticks, after which the segments go dark.
// Configuration is a plain write port (enable, index, data), to be written
// while no item is in flight; the block itself does not enforce this.
// An item is registered on acceptance; its result is registered when the
// item is applied, which waits while a stalled result holds the output.
// One item is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result holds, one more item is taken into
// the input register if it is empty, and then in_ready_o drops.
// After reset the display is dark, the scan starts at digit 0, the digits
// are zero and the configuration registers hold their default values.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_unit #(
  parameter int unsigned NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ssd_pkg::CMD_W-1:0]      cmd_i,
  input  logic [ssd_pkg::VALUE_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssd_pkg::SEG_W-1:0]      segments_o,
  output logic [ssd_pkg::SEL_W-1:0]      digit_select_o,
  input  logic                           cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              in_valid_q;
  ssd_pkg::item_t    item_q;
  logic              out_valid_q;
  ssd_pkg::result_t  result_q;
  ssd_pkg::result_t  result_d;
  ssd_pkg::step_t    step;
  logic              fire;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign step.fire  = fire;
  assign step.item  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd   <= ssd_pkg::cmd_e'(cmd_i);
      item_q.value <= value_i;
    end
  end

  ssd_scan_ctrl #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segments_o     = result_q.segments;
  assign digit_select_o = result_q.digit_select;

endmodule

FILE: rtl/seven_segment_scan_driver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_checker: port-level checks
// Watches the ports of the scan driver and flags results and handshakes
// that the design should never show.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ssd_pkg::SEG_W-1:0]      segments_o,
  input logic [ssd_pkg::SEL_W-1:0]      digit_select_o
);

  // At most one digit is driven at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_select_o))
    else $error("digit select is not one-hot");

  // With no digit selected, every segment is dark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (digit_select_o == '0)) |-> (segments_o == '0))
    else $error("segments lit while no digit is selected");

  // A ready receiver never holds up the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while the output drains");

  // A new result is registered from an item that was taken into the input
  // register before it, so each rise of the result has a matching item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching item");

  // A stalled result holds its pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(segments_o) && $stable(digit_select_o)))
    else $error("stalled result changed");

endmodule

bind seven_segment_scan_driver_unit seven_segment_scan_driver_checker u_checker (.*);
